@@ rtl/eun_pkg.sv @@
`default_nettype none
package eun_pkg;

  localparam int COORD_W       = 32;
  localparam int OUT_FRAC_BITS = 30;
  localparam int FIELD_W       = 32;
  localparam int MAG_W         = 30;

  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int GRP_N   = (CROSS_W + 7) / 8;
  localparam int LEN_W   = $clog2(CROSS_W + 1);

  localparam int RAD_W    = 2 * MAG_W + 4;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int SQ_ITERS = RAD_W / 2;
  localparam int SQ_STG   = (SQ_ITERS + 1) / 2;

  localparam int DREM_W = ROOT_W + 1;
  localparam int Q_W    = OUT_FRAC_BITS + 2;
  localparam int DV_STG = (Q_W + 1) / 2;
  localparam int NEG_W  = ((Q_W > FIELD_W) ? Q_W : FIELD_W) + 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    MODE_LINE  = 2'd0,
    MODE_TRI   = 2'd1,
    MODE_QUAD  = 2'd2,
    MODE_UNSUP = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_UNSUP = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]                 mode;
    logic signed [FIELD_W-1:0]  x0;
    logic signed [FIELD_W-1:0]  y0;
    logic signed [FIELD_W-1:0]  z0;
    logic signed [FIELD_W-1:0]  x1;
    logic signed [FIELD_W-1:0]  y1;
    logic signed [FIELD_W-1:0]  z1;
    logic signed [FIELD_W-1:0]  x2;
    logic signed [FIELD_W-1:0]  y2;
    logic signed [FIELD_W-1:0]  z2;
  } in_word_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0]  norm_x;
    logic signed [FIELD_W-1:0]  norm_y;
    logic signed [FIELD_W-1:0]  norm_z;
    logic [1:0]                 status;
  } out_word_t;

  // normalized magnitudes handed from front to back
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic [1:0]            status;
  } qword_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

@@ rtl/element_unit_normal.sv @@
// Throughput: one word per cycle; the back end never stalls, so busy stays low.
// Most of the pipeline depth is in the 16-stage square-root pipeline and the 16-stage divider.
// Reset: synchronous active-low rst_n clears all valid bits and queue pointers.
// The receiver cannot stall: out_valid is a one-cycle strobe.
`default_nettype none
module element_unit_normal (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire eun_pkg::in_word_t  in_data,
  output logic                    out_valid,
  output eun_pkg::out_word_t      out_data
);

  // front end: edge vectors, cross product, bit length, normalize (6 stages)
  logic             push;
  logic             pop;
  eun_pkg::qword_t  push_data;
  eun_pkg::qword_t  pop_data;
  eun_pkg::q_stat_t q_stat;

  eun_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // short queue parts the front from the back
  eun_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // back end drains one word every cycle it has one
  assign pop = !q_stat.empty;

  // back end: squares, sum, square root, divide, round
  eun_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // queue must never be written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full))
    else $error("queue overflow");

  // flagged results carry a zero vector
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != eun_pkg::ST_OK) |->
      (out_data.norm_x == '0 && out_data.norm_y == '0 && out_data.norm_z == '0))
    else $error("nonzero normal on flagged result");

  // an accepted word passes through the front stages and reaches the queue; back end never stalls
  a_front_push: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !q_stat.full) |-> ##6 push)
    else $error("front lost a word");

endmodule
`default_nettype wire

@@ rtl/eun_front.sv @@
`default_nettype none
module eun_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire eun_pkg::in_word_t in_data,
  input  wire eun_pkg::q_stat_t  q_stat,
  output logic                   push,
  output eun_pkg::qword_t        push_data
);

  localparam int DW = eun_pkg::DIFF_W;
  localparam int PW = eun_pkg::PROD_W;
  localparam int CW = eun_pkg::CROSS_W;
  localparam int GN = eun_pkg::GRP_N;
  localparam int LW = eun_pkg::LEN_W;
  localparam int MW = eun_pkg::MAG_W;
  localparam int KW = eun_pkg::COORD_W;

  logic adv;

  // stage 1: edge vectors
  logic                 s1_vld_r;
  logic [1:0]           s1_mode_r;
  logic signed [DW-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  // stage 2: partial products
  logic                 s2_vld_r;
  logic [1:0]           s2_mode_r;
  logic signed [DW-1:0] s2_ax_r, s2_ay_r;
  logic signed [PW-1:0] p_r [6];
  // stage 3: cross components, sign and magnitude
  logic                 s3_vld_r;
  logic [1:0]           s3_mode_r;
  logic [2:0][CW-1:0]   s3_abs_r;
  logic [2:0]           s3_neg_r;
  logic [2:0][CW-1:0]   abs_nxt;
  logic [2:0]           neg_nxt;
  // stage 4: per-byte leading one
  logic                 s4_vld_r;
  logic [1:0]           s4_mode_r;
  logic [2:0][CW-1:0]   s4_abs_r;
  logic [2:0]           s4_neg_r;
  logic [GN-1:0]        grp_nz_r;
  logic [GN-1:0][2:0]   grp_msb_r;
  logic [GN-1:0]        grp_nz_nxt;
  logic [GN-1:0][2:0]   grp_msb_nxt;
  // stage 5: bit length
  logic                 s5_vld_r;
  logic [1:0]           s5_mode_r;
  logic [2:0][CW-1:0]   s5_abs_r;
  logic [2:0]           s5_neg_r;
  logic [LW-1:0]        len_r;
  logic [LW-1:0]        len_nxt;
  // stage 6: normalized word
  logic                 s6_vld_r;
  eun_pkg::qword_t      s6_r;
  eun_pkg::qword_t      s6_nxt;

  assign adv       = !(s6_vld_r && q_stat.full);
  assign busy      = !adv;
  assign push      = s6_vld_r && !q_stat.full;
  assign push_data = s6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= start;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode_r <= in_data.mode;
      ax_r <= DW'(signed'(in_data.x1[KW-1:0])) - DW'(signed'(in_data.x0[KW-1:0]));
      ay_r <= DW'(signed'(in_data.y1[KW-1:0])) - DW'(signed'(in_data.y0[KW-1:0]));
      az_r <= DW'(signed'(in_data.z1[KW-1:0])) - DW'(signed'(in_data.z0[KW-1:0]));
      bx_r <= DW'(signed'(in_data.x2[KW-1:0])) - DW'(signed'(in_data.x0[KW-1:0]));
      by_r <= DW'(signed'(in_data.y2[KW-1:0])) - DW'(signed'(in_data.y0[KW-1:0]));
      bz_r <= DW'(signed'(in_data.z2[KW-1:0])) - DW'(signed'(in_data.z0[KW-1:0]));

      s2_mode_r <= s1_mode_r;
      s2_ax_r   <= ax_r;
      s2_ay_r   <= ay_r;
      p_r[0]    <= PW'(ay_r) * PW'(bz_r);
      p_r[1]    <= PW'(az_r) * PW'(by_r);
      p_r[2]    <= PW'(az_r) * PW'(bx_r);
      p_r[3]    <= PW'(ax_r) * PW'(bz_r);
      p_r[4]    <= PW'(ax_r) * PW'(by_r);
      p_r[5]    <= PW'(ay_r) * PW'(bx_r);

      s3_mode_r <= s2_mode_r;
      s3_abs_r  <= abs_nxt;
      s3_neg_r  <= neg_nxt;

      s4_mode_r <= s3_mode_r;
      s4_abs_r  <= s3_abs_r;
      s4_neg_r  <= s3_neg_r;
      grp_nz_r  <= grp_nz_nxt;
      grp_msb_r <= grp_msb_nxt;

      s5_mode_r <= s4_mode_r;
      s5_abs_r  <= s4_abs_r;
      s5_neg_r  <= s4_neg_r;
      len_r     <= len_nxt;

      s6_r <= s6_nxt;
    end
  end

  // cross product, or rotated edge for a line
  always_comb begin
    logic signed [2:0][CW-1:0] cs;
    if (s2_mode_r == eun_pkg::MODE_LINE) begin
      cs[0] = CW'(s2_ay_r);
      cs[1] = -CW'(s2_ax_r);
      cs[2] = '0;
    end else begin
      cs[0] = CW'(p_r[0]) - CW'(p_r[1]);
      cs[1] = CW'(p_r[2]) - CW'(p_r[3]);
      cs[2] = CW'(p_r[4]) - CW'(p_r[5]);
    end
    for (int i = 0; i < 3; i++) begin
      neg_nxt[i] = cs[i][CW-1];
      abs_nxt[i] = neg_nxt[i] ? CW'(-cs[i]) : CW'(cs[i]);
    end
  end

  always_comb begin
    logic [GN*8-1:0] orv;
    orv = (GN*8)'(s3_abs_r[0] | s3_abs_r[1] | s3_abs_r[2]);
    for (int g = 0; g < GN; g++) begin
      grp_nz_nxt[g]  = |orv[g*8 +: 8];
      grp_msb_nxt[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (orv[g*8+b]) grp_msb_nxt[g] = 3'(b);
      end
    end
  end

  always_comb begin
    len_nxt = '0;
    for (int g = 0; g < GN; g++) begin
      if (grp_nz_r[g]) len_nxt = LW'(g * 8) + LW'(grp_msb_r[g]) + LW'(1);
    end
  end

  // scale the largest magnitude to exactly MW bits and set the status; unsupported words carry zero magnitudes
  always_comb begin
    s6_nxt.neg = s5_neg_r;
    for (int i = 0; i < 3; i++) begin
      if (len_r > LW'(MW)) s6_nxt.mag[i] = MW'(s5_abs_r[i] >> (len_r - LW'(MW)));
      else                 s6_nxt.mag[i] = s5_abs_r[i][MW-1:0] << (LW'(MW) - len_r);
    end
    if (s5_mode_r == eun_pkg::MODE_UNSUP) begin
      s6_nxt.status = eun_pkg::ST_UNSUP;
      s6_nxt.mag    = '0;
    end else if (len_r == '0) begin
      s6_nxt.status = eun_pkg::ST_DEGEN;
    end else begin
      s6_nxt.status = eun_pkg::ST_OK;
    end
  end

endmodule
`default_nettype wire

@@ rtl/eun_fifo.sv @@
`default_nettype none
module eun_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire eun_pkg::qword_t  push_data,
  input  wire logic             pop,
  output eun_pkg::qword_t       pop_data,
  output eun_pkg::q_stat_t      q_stat
);

  localparam int PTW = eun_pkg::QPTR_W;
  localparam int CNW = eun_pkg::QCNT_W;

  eun_pkg::qword_t mem_r [eun_pkg::QDEPTH];
  logic [PTW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNW-1:0]  cnt_r, cnt_nxt;

  assign cnt_nxt      = cnt_r + CNW'(push) - CNW'(pop);
  assign q_stat.full  = (cnt_r == CNW'(eun_pkg::QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_data     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

@@ rtl/eun_back.sv @@
`default_nettype none
module eun_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             pop,
  input  wire eun_pkg::qword_t  pop_data,
  output logic                  out_valid,
  output eun_pkg::out_word_t    out_data
);

  localparam int MW  = eun_pkg::MAG_W;
  localparam int RW  = eun_pkg::RAD_W;
  localparam int TW  = eun_pkg::ROOT_W;
  localparam int EW  = eun_pkg::REM_W;
  localparam int DRW = eun_pkg::DREM_W;
  localparam int QW  = eun_pkg::Q_W;
  localparam int NW  = eun_pkg::NEG_W;
  localparam int FW  = eun_pkg::FIELD_W;
  localparam int OFB = eun_pkg::OUT_FRAC_BITS;

  typedef struct packed {
    logic                  valid;
    logic [RW-1:0]         rad;
    logic [EW-1:0]         rem;
    logic [TW-1:0]         root;
    logic [2:0][MW-1:0]    mag;
    logic [2:0]            neg;
    logic [1:0]            status;
  } sq_t;

  typedef struct packed {
    logic                  valid;
    logic [TW-1:0]         r;
    logic [2:0][DRW-1:0]   rem;
    logic [2:0][QW-1:0]    q;
    logic [2:0]            neg;
    logic [1:0]            status;
  } dv_t;

  // squares
  logic                  b1_vld_r;
  logic [2:0][2*MW-1:0]  sq_r;
  eun_pkg::qword_t       b1_r;
  // radicand
  logic                  b2_vld_r;
  logic [RW-1:0]         rad_r;
  eun_pkg::qword_t       b2_r;

  sq_t sq_in  [eun_pkg::SQ_STG];
  sq_t sq_nxt [eun_pkg::SQ_STG];
  sq_t sq_st_r[eun_pkg::SQ_STG];
  dv_t dv_in  [eun_pkg::DV_STG];
  dv_t dv_nxt [eun_pkg::DV_STG];
  dv_t dv_st_r[eun_pkg::DV_STG];

  logic               out_vld_r;
  eun_pkg::out_word_t out_r, out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r  <= 1'b0;
      b2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      b1_vld_r  <= pop;
      b2_vld_r  <= b1_vld_r;
      out_vld_r <= dv_st_r[eun_pkg::DV_STG-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) sq_r[i] <= (2*MW)'(pop_data.mag[i]) * (2*MW)'(pop_data.mag[i]);
    b1_r  <= pop_data;
    rad_r <= (RW'(sq_r[0]) + RW'(sq_r[1]) + RW'(sq_r[2])) << 2;
    b2_r  <= b1_r;
    out_r <= out_nxt;
  end

  genvar k;
  generate
    for (k = 0; k < eun_pkg::SQ_STG; k++) begin : g_sqrt
      if (k == 0) begin : g_head
        assign sq_in[k] = '{valid: b2_vld_r, rad: rad_r, rem: '0, root: '0,
                            mag: b2_r.mag, neg: b2_r.neg, status: b2_r.status};
      end else begin : g_link
        assign sq_in[k] = sq_st_r[k-1];
      end

      // two result bits per stage
      always_comb begin
        logic [EW-1:0] rt;
        logic [EW-1:0] trial;
        sq_nxt[k] = sq_in[k];
        for (int j = 0; j < 2; j++) begin
          if (k * 2 + j < eun_pkg::SQ_ITERS) begin
            rt    = {sq_nxt[k].rem[EW-3:0], sq_nxt[k].rad[RW-1 -: 2]};
            trial = {sq_nxt[k].root, 2'b01};
            sq_nxt[k].rad = sq_nxt[k].rad << 2;
            if (rt >= trial) begin
              sq_nxt[k].rem  = rt - trial;
              sq_nxt[k].root = {sq_nxt[k].root[TW-2:0], 1'b1};
            end else begin
              sq_nxt[k].rem  = rt;
              sq_nxt[k].root = {sq_nxt[k].root[TW-2:0], 1'b0};
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) sq_st_r[k].valid <= 1'b0;
        else        sq_st_r[k] <= sq_nxt[k];
      end
    end

    for (k = 0; k < eun_pkg::DV_STG; k++) begin : g_div
      if (k == 0) begin : g_head
        always_comb begin
          dv_in[k].valid  = sq_st_r[eun_pkg::SQ_STG-1].valid;
          dv_in[k].r      = sq_st_r[eun_pkg::SQ_STG-1].root;
          dv_in[k].neg    = sq_st_r[eun_pkg::SQ_STG-1].neg;
          dv_in[k].status = sq_st_r[eun_pkg::SQ_STG-1].status;
          dv_in[k].q      = '0;
          for (int i = 0; i < 3; i++) begin
            dv_in[k].rem[i] = DRW'(sq_st_r[eun_pkg::SQ_STG-1].mag[i]);
          end
        end
      end else begin : g_link
        assign dv_in[k] = dv_st_r[k-1];
      end

      // restoring division, two quotient bits per stage for each component
      always_comb begin
        logic [DRW-1:0] t;
        dv_nxt[k] = dv_in[k];
        for (int j = 0; j < 2; j++) begin
          if (k * 2 + j < QW) begin
            for (int i = 0; i < 3; i++) begin
              t = {dv_nxt[k].rem[i][DRW-2:0], 1'b0};
              if (t >= DRW'(dv_nxt[k].r)) begin
                dv_nxt[k].rem[i] = t - DRW'(dv_nxt[k].r);
                dv_nxt[k].q[i]   = {dv_nxt[k].q[i][QW-2:0], 1'b1};
              end else begin
                dv_nxt[k].rem[i] = t;
                dv_nxt[k].q[i]   = {dv_nxt[k].q[i][QW-2:0], 1'b0};
              end
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) dv_st_r[k].valid <= 1'b0;
        else        dv_st_r[k] <= dv_nxt[k];
      end
    end
  endgenerate

  // round half up, clamp to 1.0, apply sign
  always_comb begin
    logic [QW:0]          qs;
    logic [QW-1:0]        qh;
    logic signed [NW-1:0] v;
    logic [2:0][FW-1:0]   res;
    for (int i = 0; i < 3; i++) begin
      qs = (QW+1)'(dv_st_r[eun_pkg::DV_STG-1].q[i]) + (QW+1)'(1);
      qh = qs[QW:1];
      if (qh > (QW'(1) << OFB)) qh = QW'(1) << OFB;
      v  = NW'(qh);
      if (dv_st_r[eun_pkg::DV_STG-1].neg[i]) v = -v;
      res[i] = v[FW-1:0];
    end
    out_nxt.status = dv_st_r[eun_pkg::DV_STG-1].status;
    if (dv_st_r[eun_pkg::DV_STG-1].status != eun_pkg::ST_OK) res = '0;
    out_nxt.norm_x = res[0];
    out_nxt.norm_y = res[1];
    out_nxt.norm_z = res[2];
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`default_nettype none
module testbench;

  // Pipeline latency of the block; used for end drain only.
  localparam int PIPE_LAT = 42;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  eun_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  eun_pkg::out_word_t out_data;

  // Idle percentage for the sender; the receiver cannot stall.
  int unsigned send_idle_pct = 0;

  eun_pkg::out_word_t normal_q[$];
  int unsigned mismatch_cnt = 0;

  always #2 clk = ~clk;

  element_unit_normal dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // Bit length of a nonnegative magnitude.
  function automatic int bit_len(logic [127:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 128; i++) begin
      if (v[i]) n = i + 1;
    end
    return n;
  endfunction

  // Integer square root, floor.
  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Predicted unit normal for one element word.
  function automatic eun_pkg::out_word_t unit_normal(eun_pkg::in_word_t w);
    eun_pkg::out_word_t o;
    logic signed [127:0] c[3];
    logic signed [127:0] ax, ay, az, bx, by, bz;
    logic [127:0]  cm[3];
    logic          neg[3];
    logic [63:0]   mag[3];
    logic [63:0]   sum, root, q, one;
    logic [127:0]  num;
    int            len;
    logic signed [31:0] comp[3];
    o = '0;
    len = 0;
    one = 64'd1 << eun_pkg::OUT_FRAC_BITS;
    if (w.mode == eun_pkg::MODE_UNSUP) begin
      o.status = eun_pkg::ST_UNSUP;
      return o;
    end
    ax = w.x1 - w.x0; ay = w.y1 - w.y0; az = w.z1 - w.z0;
    bx = w.x2 - w.x0; by = w.y2 - w.y0; bz = w.z2 - w.z0;
    if (w.mode == eun_pkg::MODE_LINE) begin
      c[0] = ay; c[1] = -ax; c[2] = 0;
    end else begin
      c[0] = ay * bz - az * by;
      c[1] = az * bx - ax * bz;
      c[2] = ax * by - ay * bx;
    end
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i] < 0;
      cm[i] = neg[i] ? -c[i] : c[i];
      if (bit_len(cm[i]) > len) len = bit_len(cm[i]);
    end
    if (len == 0) begin
      o.status = eun_pkg::ST_DEGEN;
      return o;
    end
    for (int i = 0; i < 3; i++) begin
      if (len > 30) mag[i] = 64'(cm[i] >> (len - 30));
      else mag[i] = 64'(cm[i] << (30 - len));
    end
    sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    root = floor_sqrt(sum << 2);
    for (int i = 0; i < 3; i++) begin
      num = {64'd0, mag[i]} << (eun_pkg::OUT_FRAC_BITS + 2);
      q = 64'(num / root);
      q = (q + 1) >> 1;
      if (q > one) q = one;
      comp[i] = neg[i] ? -32'(q) : 32'(q);
    end
    o.norm_x = comp[0];
    o.norm_y = comp[1];
    o.norm_z = comp[2];
    o.status = eun_pkg::ST_OK;
    return o;
  endfunction

  // Send one word; wait out the handshake, random idle before.
  // start stays high afterwards so words can go back to back.
  task automatic send_word(eun_pkg::in_word_t w);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    normal_q.push_back(unit_normal(w));
  endtask

  // Result checker, sampled at the accepting edge.
  always @(posedge clk) begin
    eun_pkg::out_word_t want;
    if (rst_n && out_valid) begin
      if (normal_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected word %h", out_data);
      end else begin
        want = normal_q.pop_front();
        if (want.norm_x !== out_data.norm_x || want.norm_y !== out_data.norm_y ||
            want.norm_z !== out_data.norm_z || want.status !== out_data.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp %h %h %h %0d got %h %h %h %0d",
                     want.norm_x, want.norm_y, want.norm_z, want.status,
                     out_data.norm_x, out_data.norm_y, out_data.norm_z,
                     out_data.status);
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord(int sel);
    case (sel)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom();
    endcase
  endfunction

  function automatic eun_pkg::in_word_t rand_word();
    eun_pkg::in_word_t w;
    int sel;
    sel = $urandom_range(0, 9);
    w.mode = $urandom_range(0, 15) == 0 ? eun_pkg::MODE_UNSUP : 2'($urandom_range(0, 2));
    w.x0 = rand_coord(sel > 7 ? $urandom_range(0, 3) : (sel > 4 ? 2 : 3));
    w.y0 = rand_coord(sel > 7 ? $urandom_range(0, 3) : (sel > 4 ? 2 : 3));
    w.z0 = rand_coord(sel > 7 ? $urandom_range(0, 3) : (sel > 4 ? 2 : 3));
    w.x1 = rand_coord(sel > 7 ? $urandom_range(0, 3) : (sel > 4 ? 2 : 3));
    w.y1 = rand_coord(sel > 7 ? $urandom_range(0, 3) : (sel > 4 ? 2 : 3));
    w.z1 = rand_coord(sel > 7 ? $urandom_range(0, 3) : (sel > 4 ? 2 : 3));
    w.x2 = rand_coord(sel > 7 ? $urandom_range(0, 3) : (sel > 4 ? 2 : 3));
    w.y2 = rand_coord(sel > 7 ? $urandom_range(0, 3) : (sel > 4 ? 2 : 3));
    w.z2 = rand_coord(sel > 7 ? $urandom_range(0, 3) : (sel > 4 ? 2 : 3));
    // collinear / coincident nodes now and then to hit the zero-length case
    if (sel == 0) begin
      w.x1 = w.x0; w.y1 = w.y0; w.z1 = w.z0;
    end
    return w;
  endfunction

  function automatic eun_pkg::in_word_t mk(logic [1:0] m, logic [31:0] a, b, c, d, e, f,
                                           g, h, k);
    eun_pkg::in_word_t w;
    w.mode = m;
    w.x0 = a; w.y0 = b; w.z0 = c; w.x1 = d; w.y1 = e; w.z1 = f;
    w.x2 = g; w.y2 = h; w.z2 = k;
    return w;
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (normal_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    int one;
    one = 32'h0001_0000;
    send_word(mk(eun_pkg::MODE_LINE, 0, 0, 0, one, 0, 0, 0, 0, 0));
    send_word(mk(eun_pkg::MODE_LINE, 0, 0, 5, 0, one, 9, 3, 3, 3));
    send_word(mk(eun_pkg::MODE_LINE, 7, 7, 0, 7, 7, 0, 1, 2, 3));   // zero length line
    send_word(mk(eun_pkg::MODE_TRI, 0, 0, 0, one, 0, 0, 0, one, 0));
    send_word(mk(eun_pkg::MODE_QUAD, 0, 0, 0, 0, one, 0, 0, 0, one));
    send_word(mk(eun_pkg::MODE_TRI, 0, 0, 0, one, one, one,
                 2*one, 2*one, 2*one));                              // collinear
    send_word(mk(eun_pkg::MODE_TRI, 1, 2, 3, 1, 2, 3, 1, 2, 3));     // coincident
    send_word(mk(eun_pkg::MODE_UNSUP, 1, 2, 3, 4, 5, 6, 7, 8, 9));   // unsupported type
    send_word(mk(eun_pkg::MODE_UNSUP, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // coordinate extremes, opposite corners
    send_word(mk(eun_pkg::MODE_LINE, 32'h8000_0000, 32'h8000_0000, 0,
                 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0));
    send_word(mk(eun_pkg::MODE_TRI, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
    send_word(mk(eun_pkg::MODE_QUAD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
    send_word(mk(eun_pkg::MODE_QUAD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                 32'hffff_ffff, 32'hffff_ffff));
    // tiny components: left-shift normalization; oblique to probe rounding
    send_word(mk(eun_pkg::MODE_TRI, 0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_word(mk(eun_pkg::MODE_TRI, 0, 0, 0, 1, 1, 0, 0, 1, 1));
    send_word(mk(eun_pkg::MODE_LINE, 0, 0, 0, 3, 4, 0, 0, 0, 0));
    send_word(mk(eun_pkg::MODE_LINE, 0, 0, 0, 1, 1, 0, 0, 0, 0));
    send_word(mk(eun_pkg::MODE_TRI, 0, 0, 0, 1, 2, 3, 4, 5, 6));
    // pause until everything is out
    drain();
  endtask

  task automatic test_random(int unsigned cnt, int unsigned idle_pct);
    send_idle_pct = idle_pct;
    repeat (cnt) send_word(rand_word());
    send_idle_pct = 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(400, 0);
    test_random(400, 47);
    drain();
    test_random(300, 7);
    test_random(150, 0);
    drain();
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (mismatch_cnt == 0 && normal_q.size() == 0) begin
      $display("element_unit_normal test passed");
    end else begin
      $display("element_unit_normal test failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("element_unit_normal test failed");
    $finish;
  end

endmodule
`default_nettype wire
